/* rtl/pdbf_pkg.sv */
// ----------------------------------------------------------------------------
// pdbf_pkg: shared types and constants for the pair distance band filter
// Holds the field widths, the configuration register map and the
// structures that carry words between the pipeline stages.
// ----------------------------------------------------------------------------
package pdbf_pkg;

  localparam int NUM_BANDS     = 2;
  localparam int MAX_BANDS     = 2;
  localparam int COORD_BITS    = 24;
  localparam int POS_BITS      = 16;
  localparam int TAG_BITS      = 32;
  localparam int ID_BITS       = 31;
  localparam int LIMIT_BITS    = 31;
  localparam int BOUND_BITS    = 52;
  localparam int BANDS_W       = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 52;

  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int DIST_BITS  = SQ_BITS + 2;
  localparam int CMP_BITS   = (DIST_BITS > BOUND_BITS) ? DIST_BITS : BOUND_BITS;
  localparam int TDIFF_BITS = TAG_BITS + 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SELF_MODE  = 3'd0,
    CFG_BANDS_USED = 3'd1,
    CFG_TAG_LIMIT  = 3'd2,
    CFG_BAND0_LOW  = 3'd3,
    CFG_BAND0_HIGH = 3'd4,
    CFG_BAND1_LOW  = 3'd5,
    CFG_BAND1_HIGH = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic                  self_mode;
    logic [BANDS_W-1:0]    bands_used;
    logic [LIMIT_BITS-1:0] tag_diff_limit;
    logic [BOUND_BITS-1:0] band0_low;
    logic [BOUND_BITS-1:0] band0_high;
    logic [BOUND_BITS-1:0] band1_low;
    logic [BOUND_BITS-1:0] band1_high;
  } cfg_t;

  // One candidate pair as it arrives on the input channel.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] row_x;
    logic signed [COORD_BITS-1:0] row_y;
    logic signed [COORD_BITS-1:0] row_z;
    logic signed [TAG_BITS-1:0]   row_tag;
    logic [ID_BITS-1:0]           row_id;
    logic [POS_BITS-1:0]          row_pos;
    logic signed [COORD_BITS-1:0] col_x;
    logic signed [COORD_BITS-1:0] col_y;
    logic signed [COORD_BITS-1:0] col_z;
    logic signed [TAG_BITS-1:0]   col_tag;
    logic [ID_BITS-1:0]           col_id;
    logic [POS_BITS-1:0]          col_pos;
  } pair_t;

  // Pair after the squaring stage.
  typedef struct packed {
    logic [SQ_BITS-1:0] sq_x;
    logic [SQ_BITS-1:0] sq_y;
    logic [SQ_BITS-1:0] sq_z;
    logic               keep;
    logic [ID_BITS-1:0] row_id;
    logic [ID_BITS-1:0] col_id;
  } sq_t;

endpackage

/* rtl/pdbf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pdbf_cfg_regs: configuration register file
// Decodes the write port into the seven filter settings.
// ----------------------------------------------------------------------------
module pdbf_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pdbf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [pdbf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output pdbf_pkg::cfg_t                      cfg
);

  pdbf_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.self_mode      <= 1'b0;
      cfg_r.bands_used     <= pdbf_pkg::BANDS_W'(1);
      cfg_r.tag_diff_limit <= '0;
      cfg_r.band0_low      <= '0;
      cfg_r.band0_high     <= '0;
      cfg_r.band1_low      <= '0;
      cfg_r.band1_high     <= '0;
    end else if (cfg_we) begin
      unique case (pdbf_pkg::cfg_idx_t'(cfg_index))
        pdbf_pkg::CFG_SELF_MODE:  cfg_r.self_mode      <= cfg_wdata[0];
        pdbf_pkg::CFG_BANDS_USED: cfg_r.bands_used     <= cfg_wdata[pdbf_pkg::BANDS_W-1:0];
        pdbf_pkg::CFG_TAG_LIMIT:  cfg_r.tag_diff_limit <=
                                    cfg_wdata[pdbf_pkg::LIMIT_BITS-1:0];
        pdbf_pkg::CFG_BAND0_LOW:  cfg_r.band0_low  <= cfg_wdata[pdbf_pkg::BOUND_BITS-1:0];
        pdbf_pkg::CFG_BAND0_HIGH: cfg_r.band0_high <= cfg_wdata[pdbf_pkg::BOUND_BITS-1:0];
        pdbf_pkg::CFG_BAND1_LOW:  cfg_r.band1_low  <= cfg_wdata[pdbf_pkg::BOUND_BITS-1:0];
        pdbf_pkg::CFG_BAND1_HIGH: cfg_r.band1_high <= cfg_wdata[pdbf_pkg::BOUND_BITS-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/pdbf_square.sv */
// ----------------------------------------------------------------------------
// pdbf_square: input register and squaring stage
// Registers the incoming pair, forms the per-axis squared differences,
// the tag and position checks, and holds them in the next register.
// ----------------------------------------------------------------------------
module pdbf_square (
  input  logic            clk,
  input  logic            rst_n,
  input  pdbf_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  pdbf_pkg::pair_t in_pair,
  output logic            sq_valid,
  input  logic            sq_ready,
  output pdbf_pkg::sq_t   sq_word
);

  logic            s0_valid_r;
  pdbf_pkg::pair_t s0_r;
  logic            s1_valid_r;
  pdbf_pkg::sq_t   s1_r;
  logic            s1_open;
  pdbf_pkg::sq_t   sq_nxt;

  logic signed [pdbf_pkg::DIFF_BITS-1:0]  dx, dy, dz;
  logic [pdbf_pkg::COORD_BITS-1:0]        mx, my, mz;
  logic signed [pdbf_pkg::TDIFF_BITS-1:0] tdiff;
  logic [pdbf_pkg::TDIFF_BITS-1:0]        tabs;
  logic                                   tag_ok;
  logic                                   pos_ok;

  assign s1_open  = !s1_valid_r || sq_ready;
  assign in_ready = !s0_valid_r || s1_open;

  always_comb begin
    dx = pdbf_pkg::DIFF_BITS'(s0_r.col_x) - pdbf_pkg::DIFF_BITS'(s0_r.row_x);
    dy = pdbf_pkg::DIFF_BITS'(s0_r.col_y) - pdbf_pkg::DIFF_BITS'(s0_r.row_y);
    dz = pdbf_pkg::DIFF_BITS'(s0_r.col_z) - pdbf_pkg::DIFF_BITS'(s0_r.row_z);
    // magnitude of a difference of two COORD_BITS values fits COORD_BITS bits
    mx = dx[pdbf_pkg::DIFF_BITS-1] ? pdbf_pkg::COORD_BITS'(-dx) : pdbf_pkg::COORD_BITS'(dx);
    my = dy[pdbf_pkg::DIFF_BITS-1] ? pdbf_pkg::COORD_BITS'(-dy) : pdbf_pkg::COORD_BITS'(dy);
    mz = dz[pdbf_pkg::DIFF_BITS-1] ? pdbf_pkg::COORD_BITS'(-dz) : pdbf_pkg::COORD_BITS'(dz);

    tdiff  = pdbf_pkg::TDIFF_BITS'(s0_r.col_tag) - pdbf_pkg::TDIFF_BITS'(s0_r.row_tag);
    tabs   = tdiff[pdbf_pkg::TDIFF_BITS-1] ? pdbf_pkg::TDIFF_BITS'(-tdiff)
                                           : pdbf_pkg::TDIFF_BITS'(tdiff);
    tag_ok = tabs > pdbf_pkg::TDIFF_BITS'(cfg.tag_diff_limit);
    pos_ok = !cfg.self_mode || (s0_r.col_pos > s0_r.row_pos);

    sq_nxt.sq_x   = pdbf_pkg::SQ_BITS'(mx) * pdbf_pkg::SQ_BITS'(mx);
    sq_nxt.sq_y   = pdbf_pkg::SQ_BITS'(my) * pdbf_pkg::SQ_BITS'(my);
    sq_nxt.sq_z   = pdbf_pkg::SQ_BITS'(mz) * pdbf_pkg::SQ_BITS'(mz);
    sq_nxt.keep   = tag_ok && pos_ok;
    sq_nxt.row_id = s0_r.row_id;
    sq_nxt.col_id = s0_r.col_id;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s0_valid_r <= in_valid;
      end
      if (s1_open) begin
        s1_valid_r <= s0_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_r <= in_pair;
    end
    if (s0_valid_r && s1_open) begin
      s1_r <= sq_nxt;
    end
  end

  assign sq_valid = s1_valid_r;
  assign sq_word  = s1_r;

endmodule

/* rtl/pdbf_band_emit.sv */
// ----------------------------------------------------------------------------
// pdbf_band_emit: band compare and contact output
// Sums the squares, checks each band and holds the hit mask in the
// output register, handing out one contact word per band hit.
// ----------------------------------------------------------------------------
module pdbf_band_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pdbf_pkg::cfg_t                cfg,
  input  logic                          sq_valid,
  output logic                          sq_ready,
  input  pdbf_pkg::sq_t                 sq_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_band,
  output logic [pdbf_pkg::ID_BITS-1:0]  out_first_id,
  output logic [pdbf_pkg::ID_BITS-1:0]  out_second_id,
  output logic                          out_last
);

  logic [pdbf_pkg::MAX_BANDS-1:0] mask_r;
  logic [pdbf_pkg::MAX_BANDS-1:0] mask_nxt;
  logic [pdbf_pkg::MAX_BANDS-1:0] hit;
  logic [pdbf_pkg::ID_BITS-1:0]   first_id_r;
  logic [pdbf_pkg::ID_BITS-1:0]   second_id_r;
  logic [pdbf_pkg::CMP_BITS-1:0]  dist_sq;
  logic                           band1_en;
  logic                           last_now;
  logic                           free;

  always_comb begin
    dist_sq = pdbf_pkg::CMP_BITS'(sq_word.sq_x) + pdbf_pkg::CMP_BITS'(sq_word.sq_y)
            + pdbf_pkg::CMP_BITS'(sq_word.sq_z);
    band1_en = (pdbf_pkg::NUM_BANDS > 1) && (cfg.bands_used >= pdbf_pkg::BANDS_W'(2));
    hit[0] = sq_word.keep
          && (dist_sq > pdbf_pkg::CMP_BITS'(cfg.band0_low))
          && (dist_sq < pdbf_pkg::CMP_BITS'(cfg.band0_high));
    hit[1] = sq_word.keep && band1_en
          && (dist_sq > pdbf_pkg::CMP_BITS'(cfg.band1_low))
          && (dist_sq < pdbf_pkg::CMP_BITS'(cfg.band1_high));
  end

  // Band 0 goes out first; the word is last unless band 1 still follows.
  assign last_now = !(mask_r[0] && mask_r[1]);
  assign free     = (mask_r == '0) || (out_ready && last_now);
  assign sq_ready = free;

  always_comb begin
    if (free) begin
      mask_nxt = sq_valid ? hit : '0;
    end else if (out_ready) begin
      mask_nxt = mask_r & ~pdbf_pkg::MAX_BANDS'(1);
    end else begin
      mask_nxt = mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && sq_valid) begin
      first_id_r  <= sq_word.row_id;
      second_id_r <= sq_word.col_id;
    end
  end

  assign out_valid     = |mask_r;
  assign out_band      = !mask_r[0];
  assign out_first_id  = first_id_r;
  assign out_second_id = second_id_r;
  assign out_last      = last_now;

endmodule

/* rtl/pair_distance_band_filter_unit.sv */
// ----------------------------------------------------------------------------
// pair_distance_band_filter_unit: neighbor contact filter with distance bands
// Top level: configuration registers, squaring stage, band check and output.
// ----------------------------------------------------------------------------
// Each input word is one candidate pair of points (row and column), with
// signed Q16.8 coordinates, a filament tag, an id and a list position. The
// unit forms the exact squared distance (unsigned Q34.16) and the absolute
// tag difference, and emits one contact word per distance band that the pair
// falls strictly inside, band 0 before band 1, provided the tag difference
// exceeds tag_diff_limit and, in self mode, col_pos > row_pos. A pair yields
// zero, one or two contact words; out_last marks the final one, and a pair
// with no contact yields nothing. A pair passes three registers: the input
// register loaded at its acceptance edge, the squaring register (three
// 24x24 multipliers), then the output register fed by the sum and band
// compares. One pair is accepted per cycle unless the output stalls; a
// pair that hits both bands holds the output register until both of its
// words are taken, so sustained throughput is one contact word per cycle.
// Write configuration only while the unit is idle.
// ----------------------------------------------------------------------------
module pair_distance_band_filter_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,

  // configuration write port
  input  logic                                  cfg_we,
  input  logic [pdbf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [pdbf_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,

  // candidate pair input
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pdbf_pkg::COORD_BITS-1:0] in_row_x,
  input  logic signed [pdbf_pkg::COORD_BITS-1:0] in_row_y,
  input  logic signed [pdbf_pkg::COORD_BITS-1:0] in_row_z,
  input  logic signed [pdbf_pkg::TAG_BITS-1:0]   in_row_tag,
  input  logic [pdbf_pkg::ID_BITS-1:0]          in_row_id,
  input  logic [pdbf_pkg::POS_BITS-1:0]         in_row_pos,
  input  logic signed [pdbf_pkg::COORD_BITS-1:0] in_col_x,
  input  logic signed [pdbf_pkg::COORD_BITS-1:0] in_col_y,
  input  logic signed [pdbf_pkg::COORD_BITS-1:0] in_col_z,
  input  logic signed [pdbf_pkg::TAG_BITS-1:0]   in_col_tag,
  input  logic [pdbf_pkg::ID_BITS-1:0]          in_col_id,
  input  logic [pdbf_pkg::POS_BITS-1:0]         in_col_pos,

  // contact output
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_band,
  output logic [pdbf_pkg::ID_BITS-1:0]          out_first_id,
  output logic [pdbf_pkg::ID_BITS-1:0]          out_second_id,
  output logic                                  out_last
);

  pdbf_pkg::cfg_t  cfg;
  pdbf_pkg::pair_t in_pair;
  pdbf_pkg::sq_t   sq_word;
  logic            sq_valid;
  logic            sq_ready;

  // Gather the input ports into one pair word.
  always_comb begin
    in_pair.row_x   = in_row_x;
    in_pair.row_y   = in_row_y;
    in_pair.row_z   = in_row_z;
    in_pair.row_tag = in_row_tag;
    in_pair.row_id  = in_row_id;
    in_pair.row_pos = in_row_pos;
    in_pair.col_x   = in_col_x;
    in_pair.col_y   = in_col_y;
    in_pair.col_z   = in_col_z;
    in_pair.col_tag = in_col_tag;
    in_pair.col_id  = in_col_id;
    in_pair.col_pos = in_col_pos;
  end

  // Settings: self mode, band count, tag limit and the two band windows.
  pdbf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register, then squared axis differences plus tag/position checks.
  pdbf_square u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pair  (in_pair),
    .sq_valid (sq_valid),
    .sq_ready (sq_ready),
    .sq_word  (sq_word)
  );

  // Sum, compare against each band, and emit one word per hit.
  pdbf_band_emit u_band_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .sq_valid      (sq_valid),
    .sq_ready      (sq_ready),
    .sq_word       (sq_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_band      (out_band),
    .out_first_id  (out_first_id),
    .out_second_id (out_second_id),
    .out_last      (out_last)
  );

endmodule
